FILE: rtl/core/grs_pkg.sv
// Package for the group reverse stream block: shared widths, defaults and
// the group start command that the fill side hands to the buffer side.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package grs_pkg;

   // Default sizes of the group buffer and its words
   localparam int MAX_GROUP_DEF  = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths of the channels and the group size register
   localparam int VALUE_W = 32;
   localparam int CFG_W   = 7;

   // Group size after reset
   localparam logic [CFG_W-1:0] GROUP_SIZE_RST = 7'd2;

   // Command that starts draining one finished group
   typedef struct packed {
      logic start;    // a group is complete this cycle
      logic reverse;  // full group: drain newest first
      logic eol;      // group closes the list
   } grs_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/core/grs_req_if.sv
// Input item channel of the group reverse stream block: valid/ready plus
// one list element. Depends on grs_pkg for the field width.
`default_nettype none

interface grs_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [grs_pkg::VALUE_W-1:0] value;
   logic                              end_of_list;

   modport source (output valid, output value, output end_of_list, input ready);
   modport sink   (input valid, input value, input end_of_list, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/grs_rsp_if.sv
// Result item channel of the group reverse stream block: valid/ready plus
// one reordered element and its run and list end flags. Depends on grs_pkg.
`default_nettype none

interface grs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [grs_pkg::VALUE_W-1:0] out_value;
   logic                              run_last;
   logic                              list_last;

   modport source (output valid, output out_value, output run_last, output list_last,
                   input ready);
   modport sink   (input valid, input out_value, input run_last, input list_last,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/core/grs_store.sv
// Group buffer memory with its drain sequencer and result pipeline.
// Depends on grs_pkg and the grs_rsp_if interface.
`default_nettype none

module grs_store #(
   parameter int MAX_GROUP  = grs_pkg::MAX_GROUP_DEF,
   parameter int DATA_WIDTH = grs_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // write port from the fill side
   input  wire logic                                 wr_en,
   input  wire logic [((MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1)-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0]                wr_data,
   // group start command
   input  wire grs_pkg::grs_cmd_type                 cmd,
   input  wire logic [$clog2(MAX_GROUP+1)-1:0]       cmd_count,
   output      logic                                 drain_busy,
   // results
   grs_rsp_if.source                                 rsp_chan
);

   localparam int CNT_W  = $clog2(MAX_GROUP + 1);
   localparam int ADDR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

   logic [DATA_WIDTH-1:0] mem [MAX_GROUP];

   // drain sequencer
   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic              rev_ff, rev_in;
   logic              eol_ff, eol_in;

   // read data stage
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic                  s1_vld_ff, s1_vld_in;
   logic                  s1_run_ff;
   logic                  s1_list_ff;

   // result register
   logic                          rsp_vld_ff, rsp_vld_in;
   logic [grs_pkg::VALUE_W-1:0]   rsp_value_ff;
   logic                          rsp_run_ff;
   logic                          rsp_list_ff;

   logic        rd_en;
   logic        s2_load;
   logic        last_read;
   logic [63:0] rdata_wide;

   // Move read data into the result register when it is free or being taken
   assign s2_load   = s1_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   // Issue a read only when the read data stage can take it
   assign rd_en     = busy_ff && (!s1_vld_ff || s2_load);
   assign last_read = (remain_ff == CNT_W'(1));
   assign rdata_wide = 64'(rdata_ff);

   // Memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Memory read port, data held while not reading
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff   <= mem[rd_addr_ff];
         s1_run_ff  <= last_read;
         s1_list_ff <= last_read && eol_ff;
      end
   end

   // Sequencer next state: load on start, step address and count on each read
   always_comb begin
      busy_in    = busy_ff;
      remain_in  = remain_ff;
      rd_addr_in = rd_addr_ff;
      rev_in     = rev_ff;
      eol_in     = eol_ff;
      if (cmd.start) begin
         busy_in    = 1'b1;
         remain_in  = cmd_count;
         rev_in     = cmd.reverse;
         eol_in     = cmd.eol;
         rd_addr_in = cmd.reverse ? ADDR_W'(cmd_count - CNT_W'(1)) : '0;
      end else if (rd_en) begin
         remain_in  = remain_ff - CNT_W'(1);
         rd_addr_in = rev_ff ? (rd_addr_ff - ADDR_W'(1)) : (rd_addr_ff + ADDR_W'(1));
         if (last_read) begin
            busy_in = 1'b0;
         end
      end
   end

   // Pipeline valid bits
   assign s1_vld_in  = rd_en || (s1_vld_ff && !s2_load);
   assign rsp_vld_in = s2_load || (rsp_vld_ff && !rsp_chan.ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Sequencer payload
   always_ff @(posedge clock) begin
      remain_ff  <= remain_in;
      rd_addr_ff <= rd_addr_in;
      rev_ff     <= rev_in;
      eol_ff     <= eol_in;
   end

   // Result payload, held while stalled
   always_ff @(posedge clock) begin
      if (s2_load) begin
         rsp_value_ff <= rdata_wide[grs_pkg::VALUE_W-1:0];
         rsp_run_ff   <= s1_run_ff;
         rsp_list_ff  <= s1_list_ff;
      end
   end

   assign drain_busy         = busy_ff;
   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.out_value = $signed(rsp_value_ff);
   assign rsp_chan.run_last  = rsp_run_ff;
   assign rsp_chan.list_last = rsp_list_ff;

   // No buffer write while a group is being read out
   a_no_write_in_drain: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !wr_en)
      else $error("buffer written during drain");

   // A new group starts only when the previous one has been fully read
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("group start while draining");

   // The final read ends the drain
   a_last_read_ends: assert property (@(posedge clock) disable iff (reset)
      (rd_en && last_read) |=> !busy_ff)
      else $error("drain kept running after final read");

   // Read data stage holds its word while it cannot move on
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !s2_load) |=> (s1_vld_ff && $stable(rdata_ff)))
      else $error("read data lost under stall");

endmodule

`default_nettype wire

FILE: rtl/core/group_reverse_stream_top.sv
// Group reverse stream top level: group size register and fill control.
// Depends on grs_pkg, grs_req_if, grs_rsp_if and grs_store.
//
// Usage:
//  - req_chan carries one list element per item (value, end_of_list);
//    rsp_chan returns the reordered elements with run_last on the final
//    result of a group and list_last on the final element of the list.
//  - csr_wr_en/csr_wr_data write the group size (0 acts as 1, values above
//    MAX_GROUP act as MAX_GROUP). Write it only while the block is idle.
//  - Items go into a single MAX_GROUP-word buffer, one per ready cycle.
//    When a group of group size items is complete it is read back newest
//    first; a shorter group closed by end_of_list is read back in order.
//  - The first result of a group passes through one buffer read and one
//    result register after the edge that accepts the item completing it;
//    the rest follow one per cycle while rsp_chan takes them.
//  - A group is filled and then drained through the one buffer read port;
//    req_chan.ready is low while a group is being read out.
//  - A stalled rsp_chan holds the current result; one more waits in the
//    read data stage and the buffer read stops until the receiver takes it.
//  - Reset (synchronous, active high) empties the buffer count, drops
//    pending results and sets the group size to 2.
`default_nettype none

module group_reverse_stream_top #(
   parameter int MAX_GROUP  = grs_pkg::MAX_GROUP_DEF,
   parameter int DATA_WIDTH = grs_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [grs_pkg::CFG_W-1:0]   csr_wr_data,
   grs_req_if.sink                          req_chan,
   grs_rsp_if.source                        rsp_chan
);

   localparam int CNT_W  = $clog2(MAX_GROUP + 1);
   localparam int ADDR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

   logic [grs_pkg::CFG_W-1:0] group_size_ff, group_size_in;
   logic [grs_pkg::CFG_W-1:0] eff_size;

   logic [CNT_W-1:0]          fill_ff, fill_in;
   logic [CNT_W-1:0]          fill_n;
   logic                      accept;
   logic                      full;
   logic                      complete;
   logic                      drain_busy;
   logic [63:0]               value_wide;
   grs_pkg::grs_cmd_type      cmd;

   // Clamp the group size to 1..MAX_GROUP
   always_comb begin
      if (group_size_ff == '0) begin
         eff_size = grs_pkg::CFG_W'(1);
      end else if (group_size_ff > grs_pkg::CFG_W'(MAX_GROUP)) begin
         eff_size = grs_pkg::CFG_W'(MAX_GROUP);
      end else begin
         eff_size = group_size_ff;
      end
   end

   // Take items only while no group is being read out
   assign req_chan.ready = !drain_busy;
   assign accept         = req_chan.valid && req_chan.ready;

   // Count including the item now arriving
   assign fill_n   = fill_ff + CNT_W'(1);
   assign full     = grs_pkg::CFG_W'(fill_n) >= eff_size;
   assign complete = full || req_chan.end_of_list;

   assign value_wide = 64'($unsigned(req_chan.value));

   // Start the drain when the item closes a group
   assign cmd.start   = accept && complete;
   assign cmd.reverse = full;
   assign cmd.eol     = req_chan.end_of_list;

   // Advance the fill count, clear it when a group is handed off
   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         fill_in = complete ? '0 : fill_n;
      end
   end

   assign group_size_in = csr_wr_en ? csr_wr_data : group_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         group_size_ff <= grs_pkg::GROUP_SIZE_RST;
      end else begin
         fill_ff       <= fill_in;
         group_size_ff <= group_size_in;
      end
   end

   grs_store #(
      .MAX_GROUP  (MAX_GROUP),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (accept),
      .wr_addr    (fill_ff[ADDR_W-1:0]),
      .wr_data    (value_wide[DATA_WIDTH-1:0]),
      .cmd        (cmd),
      .cmd_count  (fill_n),
      .drain_busy (drain_busy),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire
